// ===== design/hsv2rgb_pkg.sv =====
// Shared types, constants and a helper function for the HSV to RGB converter.
`timescale 1ns / 1ps

package hsv2rgb_pkg;

  // Full turn times one byte unit (65536 * 255) and half of it for rounding.
  localparam logic [23:0] TURN_BYTE = 24'd16711680;
  localparam logic [31:0] TURN_BYTE_HALF = 32'd8355840;
  // Rounding bias for a ratio over 255.
  localparam logic [15:0] BYTE_HALF = 16'd127;

  // Hue sectors.
  localparam logic [2:0] SEC_RED_YEL = 3'd0;
  localparam logic [2:0] SEC_YEL_GRN = 3'd1;
  localparam logic [2:0] SEC_GRN_CYN = 3'd2;
  localparam logic [2:0] SEC_CYN_BLU = 3'd3;
  localparam logic [2:0] SEC_BLU_MAG = 3'd4;

  typedef struct packed {
    logic [15:0] hue;
    logic [7:0]  saturation;
    logic [7:0]  brightness;
    logic [7:0]  alpha_in;
  } hsv_in_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha_out;
  } rgb_out_t;

  // After the sector split.
  typedef struct packed {
    logic        vld;
    logic [2:0]  sector;
    logic [15:0] frac;
    logic [7:0]  sat;
    logic [7:0]  val;
    logic [7:0]  alpha;
  } sec_t;

  // After the brightness products.
  typedef struct packed {
    logic        vld;
    logic [2:0]  sector;
    logic [7:0]  val;
    logic [7:0]  alpha;
    logic [31:0] xq;
    logic [31:0] xt;
    logic [15:0] pr;
  } mul_t;

  // Floor of y / 255 for any 16-bit y below 65280, by reciprocal shift and add.
  function automatic logic [7:0] div255(input logic [15:0] y);
    logic [16:0] s;
    s = {1'b0, y} + 17'd1 + {9'b0, y[15:8]};
    return s[15:8];
  endfunction

endpackage

// ===== design/hsv2rgb_sector.sv =====
// First pipeline stage: hue times six, split into sector and fraction.
`timescale 1ns / 1ps

module hsv2rgb_sector
  import hsv2rgb_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    up_vld,
  input  hsv_in_t up_data,
  output logic    up_rdy,
  output sec_t    dn_data,
  input  logic    dn_rdy
);

  sec_t        stg_r;
  sec_t        stg_nxt;
  logic        en;
  logic [18:0] scaled;

  assign en     = !stg_r.vld || dn_rdy;
  assign up_rdy = en;

  // Six times hue as four times plus two times.
  assign scaled = {1'b0, up_data.hue, 2'b00} + {2'b00, up_data.hue, 1'b0};

  always_comb begin
    stg_nxt.vld    = up_vld;
    stg_nxt.sector = scaled[18:16];
    stg_nxt.frac   = scaled[15:0];
    stg_nxt.sat    = up_data.saturation;
    stg_nxt.val    = up_data.brightness;
    stg_nxt.alpha  = up_data.alpha_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_r.vld <= 1'b0;
    end else if (en) begin
      stg_r.vld <= stg_nxt.vld;
    end
    if (en) begin
      stg_r.sector <= stg_nxt.sector;
      stg_r.frac   <= stg_nxt.frac;
      stg_r.sat    <= stg_nxt.sat;
      stg_r.val    <= stg_nxt.val;
      stg_r.alpha  <= stg_nxt.alpha;
    end
  end

  assign dn_data = stg_r;

endmodule

// ===== design/hsv2rgb_prod.sv =====
// Second and third pipeline stages: saturation terms, then brightness products.
`timescale 1ns / 1ps

module hsv2rgb_prod
  import hsv2rgb_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  sec_t up_data,
  output logic up_rdy,
  output mul_t dn_data,
  input  logic dn_rdy
);

  // Stage two registers.
  logic        v2_r;
  logic [2:0]  sector2_r;
  logic [7:0]  val2_r;
  logic [7:0]  alpha2_r;
  logic [23:0] aq2_r;
  logic [23:0] at2_r;
  logic [15:0] pn2_r;

  logic [23:0] fs;
  logic [7:0]  sinv;
  logic [23:0] aq_nxt;
  logic [23:0] at_nxt;
  logic [15:0] pn_nxt;

  mul_t stg3_r;
  mul_t stg3_nxt;

  logic en2;
  logic en3;

  assign en3    = !stg3_r.vld || dn_rdy;
  assign en2    = !v2_r || en3;
  assign up_rdy = en2;

  // 1 - f*s and 1 - (1-f)*s, both scaled by a full turn times 255.
  assign fs     = {8'b0, up_data.frac} * {16'b0, up_data.sat};
  assign sinv   = 8'd255 - up_data.sat;
  assign aq_nxt = TURN_BYTE - fs;
  assign at_nxt = {sinv, 16'b0} + fs;
  assign pn_nxt = {8'b0, up_data.val} * {8'b0, sinv};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en2) begin
      v2_r <= up_data.vld;
    end
    if (en2) begin
      sector2_r <= up_data.sector;
      val2_r    <= up_data.val;
      alpha2_r  <= up_data.alpha;
      aq2_r     <= aq_nxt;
      at2_r     <= at_nxt;
      pn2_r     <= pn_nxt;
    end
  end

  always_comb begin
    stg3_nxt.vld    = v2_r;
    stg3_nxt.sector = sector2_r;
    stg3_nxt.val    = val2_r;
    stg3_nxt.alpha  = alpha2_r;
    stg3_nxt.xq     = {24'b0, val2_r} * {8'b0, aq2_r};
    stg3_nxt.xt     = {24'b0, val2_r} * {8'b0, at2_r};
    stg3_nxt.pr     = pn2_r + BYTE_HALF;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg3_r.vld <= 1'b0;
    end else if (en3) begin
      stg3_r.vld <= stg3_nxt.vld;
    end
    if (en3) begin
      stg3_r.sector <= stg3_nxt.sector;
      stg3_r.val    <= stg3_nxt.val;
      stg3_r.alpha  <= stg3_nxt.alpha;
      stg3_r.xq     <= stg3_nxt.xq;
      stg3_r.xt     <= stg3_nxt.xt;
      stg3_r.pr     <= stg3_nxt.pr;
    end
  end

  assign dn_data = stg3_r;

endmodule

// ===== design/hsv2rgb_norm.sv =====
// Fourth and fifth pipeline stages: rounding, division by 255, sector select.
`timescale 1ns / 1ps

module hsv2rgb_norm
  import hsv2rgb_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  mul_t     up_data,
  output logic     up_rdy,
  output logic     dn_vld,
  output rgb_out_t dn_data,
  input  logic     dn_rdy
);

  // Stage four registers.
  logic        v4_r;
  logic [2:0]  sector4_r;
  logic [7:0]  val4_r;
  logic [7:0]  alpha4_r;
  logic [15:0] yq4_r;
  logic [15:0] yt4_r;
  logic [15:0] yp4_r;

  logic [31:0] sq;
  logic [31:0] st;

  // Stage five (output) registers.
  logic     v5_r;
  rgb_out_t out_r;
  rgb_out_t out_nxt;

  logic [7:0] cq;
  logic [7:0] ct;
  logic [7:0] cp;

  logic en4;
  logic en5;

  assign en5    = !v5_r || dn_rdy;
  assign en4    = !v4_r || en5;
  assign up_rdy = en4;

  // Add half the denominator and drop the full-turn factor.
  assign sq = up_data.xq + TURN_BYTE_HALF;
  assign st = up_data.xt + TURN_BYTE_HALF;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en4) begin
      v4_r <= up_data.vld;
    end
    if (en4) begin
      sector4_r <= up_data.sector;
      val4_r    <= up_data.val;
      alpha4_r  <= up_data.alpha;
      yq4_r     <= sq[31:16];
      yt4_r     <= st[31:16];
      yp4_r     <= up_data.pr;
    end
  end

  assign cq = div255(yq4_r);
  assign ct = div255(yt4_r);
  assign cp = div255(yp4_r);

  always_comb begin
    out_nxt.alpha_out = alpha4_r;
    unique case (sector4_r)
      SEC_RED_YEL: begin
        out_nxt.red = val4_r; out_nxt.green = ct;     out_nxt.blue = cp;
      end
      SEC_YEL_GRN: begin
        out_nxt.red = cq;     out_nxt.green = val4_r; out_nxt.blue = cp;
      end
      SEC_GRN_CYN: begin
        out_nxt.red = cp;     out_nxt.green = val4_r; out_nxt.blue = ct;
      end
      SEC_CYN_BLU: begin
        out_nxt.red = cp;     out_nxt.green = cq;     out_nxt.blue = val4_r;
      end
      SEC_BLU_MAG: begin
        out_nxt.red = ct;     out_nxt.green = cp;     out_nxt.blue = val4_r;
      end
      // Magenta to red, the last sector.
      default: begin
        out_nxt.red = val4_r; out_nxt.green = cp;     out_nxt.blue = cq;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (en5) begin
      v5_r <= v4_r;
    end
    if (en5) begin
      out_r <= out_nxt;
    end
  end

  assign dn_vld  = v5_r;
  assign dn_data = out_r;

endmodule

// ===== design/hsv_to_rgb_convert.sv =====
// Top level of the HSV to RGB pixel converter.
`timescale 1ns / 1ps

// The converter turns one HSV pixel into an 8-bit RGB pixel and copies the
// alpha byte across unchanged. Hue is a 16-bit fraction of a full turn, so
// it wraps naturally; saturation and brightness are bytes meaning k/255.
// Each channel is the exact rational result times 255, rounded half up,
// computed entirely in integer arithmetic. The datapath is a five-stage
// pipeline: hue times six and the sector split, the saturation terms, the
// brightness products, rounding with the full-turn factor dropped, and the
// division by 255 with the per-sector channel select, which loads the output
// register. A new pixel transfer is taken in every cycle, provided the output
// is not stalled. Each stage holds its contents while the one after it is full
// and stalled, so a stall on the output fills empty stages first and reaches
// in_stall only when the whole pipeline is occupied; no transfer is lost or
// repeated.
module hsv_to_rgb_convert
  import hsv2rgb_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  hsv_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output rgb_out_t out_data
);

  sec_t sec_data;
  mul_t mul_data;
  logic sec_rdy;
  logic prod_rdy;
  logic norm_rdy;

  hsv2rgb_sector u_sector (
    .clk     (clk),
    .rst_n   (rst_n),
    .up_vld  (in_valid),
    .up_data (in_data),
    .up_rdy  (sec_rdy),
    .dn_data (sec_data),
    .dn_rdy  (prod_rdy)
  );

  hsv2rgb_prod u_prod (
    .clk     (clk),
    .rst_n   (rst_n),
    .up_data (sec_data),
    .up_rdy  (prod_rdy),
    .dn_data (mul_data),
    .dn_rdy  (norm_rdy)
  );

  hsv2rgb_norm u_norm (
    .clk     (clk),
    .rst_n   (rst_n),
    .up_data (mul_data),
    .up_rdy  (norm_rdy),
    .dn_vld  (out_valid),
    .dn_data (out_data),
    .dn_rdy  (!out_stall)
  );

  assign in_stall = !sec_rdy;

endmodule

// ===== test/hsv_to_rgb_convert_checker.sv =====
// Checker for the HSV to RGB converter: predicts each pixel and compares results.
`timescale 1ns / 1ps

module hsv_to_rgb_convert_checker
  import hsv2rgb_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_stall,
  input  hsv_in_t  in_data,
  input  logic     out_valid,
  input  logic     out_stall,
  input  rgb_out_t out_data,
  output int       fail_count,
  output int       outstanding,
  output int       checked_count
);

  rgb_out_t rgb_expect_q[$];

  // Exact rational result of each candidate channel, rounded half up to a byte.
  function automatic rgb_out_t predict_rgb(input hsv_in_t px);
    logic [18:0] scaled;
    logic [2:0]  sector;
    logic [15:0] frac;
    logic [63:0] den;
    logic [63:0] ch_p;
    logic [63:0] ch_q;
    logic [63:0] ch_t;
    logic [7:0]  ch_v;
    rgb_out_t    res;
    scaled = px.hue * 19'd6;
    sector = scaled[18:16];
    frac   = scaled[15:0];
    den    = 64'(TURN_BYTE);
    ch_v   = px.brightness;
    ch_p   = (64'd2 * px.brightness * (64'd255 - px.saturation) + 64'd255) / 64'd510;
    ch_q   = (64'd2 * px.brightness * (den - 64'(frac) * px.saturation) + den)
             / (64'd2 * den);
    ch_t   = (64'd2 * px.brightness * (den - (64'd65536 - frac) * px.saturation) + den)
             / (64'd2 * den);
    case (sector)
      SEC_RED_YEL: begin
        res.red = ch_v;       res.green = ch_t[7:0]; res.blue = ch_p[7:0];
      end
      SEC_YEL_GRN: begin
        res.red = ch_q[7:0];  res.green = ch_v;      res.blue = ch_p[7:0];
      end
      SEC_GRN_CYN: begin
        res.red = ch_p[7:0];  res.green = ch_v;      res.blue = ch_t[7:0];
      end
      SEC_CYN_BLU: begin
        res.red = ch_p[7:0];  res.green = ch_q[7:0]; res.blue = ch_v;
      end
      SEC_BLU_MAG: begin
        res.red = ch_t[7:0];  res.green = ch_p[7:0]; res.blue = ch_v;
      end
      default: begin
        res.red = ch_v;       res.green = ch_p[7:0]; res.blue = ch_q[7:0];
      end
    endcase
    res.alpha_out = px.alpha_in;
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns: MISMATCH %s", $time, msg);
    fail_count++;
  endtask

  task automatic compare_field(input string field, input logic [7:0] got,
                               input logic [7:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0d, expected %0d", field, got, want));
  endtask

  always @(posedge clk) begin
    rgb_out_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (rgb_expect_q.size() == 0) begin
          report_mismatch("result transfer with no pixel outstanding");
        end else begin
          want = rgb_expect_q.pop_front();
          compare_field("red", out_data.red, want.red);
          compare_field("green", out_data.green, want.green);
          compare_field("blue", out_data.blue, want.blue);
          compare_field("alpha_out", out_data.alpha_out, want.alpha_out);
          checked_count <= checked_count + 1;
        end
      end
      if (in_valid && !in_stall)
        rgb_expect_q.push_back(predict_rgb(in_data));
      outstanding <= rgb_expect_q.size();
    end
  end

endmodule

// ===== test/hsv_to_rgb_convert_tb.sv =====
// Testbench top for the HSV to RGB converter: stimulus, idling and verdict.
`timescale 1ns / 1ps

// The top drives pixels into the converter and throttles the result side;
// all prediction and comparison happens in the checker instantiated beside
// the block. The stimulus opens with a directed set of pixels (hue extremes,
// the wrap just below a full turn, both sides of every sector boundary, zero
// and full saturation and brightness, alpha extremes) and then streams random
// pixels, a good share of them aimed at sector boundaries and at the edges
// of saturation and brightness, since that is where rounding is most fragile.
module hsv_to_rgb_convert_tb;
  import hsv2rgb_pkg::*;

  localparam int RANDOM_PIXELS = 1130;
  localparam int QUIET_LIMIT   = 2000;
  localparam int IDLE_PERCENT  = 23;
  // Random pixels in this window go through with neither side idling.
  localparam int STEADY_FIRST  = 500;
  localparam int STEADY_LAST   = 720;
  localparam int DRAIN_AT      = 300;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  hsv_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  rgb_out_t out_data;

  int fail_count;
  int outstanding;
  int checked_count;
  int pixels_sent = 0;
  int quiet_cycles = 0;
  logic steady = 1'b0;

  always #5 clk = ~clk;

  hsv_to_rgb_convert u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  hsv_to_rgb_convert_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data),
    .fail_count    (fail_count),
    .outstanding   (outstanding),
    .checked_count (checked_count)
  );

  // The result side stalls at random, except during the steady stretch.
  always @(posedge clk) begin
    out_stall <= !steady && ($urandom_range(99) < IDLE_PERCENT);
  end

  // The watchdog ends a run that has made no transfer on either channel for
  // far longer than any legal stall pattern could explain.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("hsv_to_rgb_convert_tb: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic hsv_in_t make_pixel(input int hue, input int sat, input int val,
                                         input int alpha);
    hsv_in_t px;
    px.hue        = hue[15:0];
    px.saturation = sat[7:0];
    px.brightness = val[7:0];
    px.alpha_in   = alpha[7:0];
    return px;
  endfunction

  // Three random pixels in eight are uniform; the rest lean on the places where the
  // sector select and the rounding are easiest to get wrong.
  function automatic hsv_in_t random_pixel();
    hsv_in_t px;
    int      edge_hue;
    px = make_pixel($urandom_range(65535), $urandom_range(255), $urandom_range(255),
                    $urandom_range(255));
    case ($urandom_range(7))
      0: px.saturation = '0;
      1: px.saturation = 8'hFF;
      2: px.brightness = ($urandom_range(1) == 0) ? 8'h00 : 8'hFF;
      3, 4: begin
        // Within a few codes of a sector boundary, including the full-turn wrap.
        edge_hue = ($urandom_range(6) * 65536 + 5) / 6 + $urandom_range(8) - 4;
        px.hue   = edge_hue[15:0];
      end
      default: ;
    endcase
    return px;
  endfunction

  // One pixel transfer. A gap may come first; otherwise valid simply stays
  // high and the payload changes at the edge that took the previous pixel.
  task automatic send_pixel(input hsv_in_t px);
    while (!steady && ($urandom_range(99) < IDLE_PERCENT)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= px;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pixels_sent++;
  endtask

  // Holds the input idle until every pixel sent so far has come back. The
  // first wait lets the checker count the transfer made at this very edge.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  initial begin
    hsv_in_t directed_px[$];
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed pixels: hue extremes, the wrap, every sector either side of
    // its boundary, grey (zero saturation), black, white and alpha extremes.
    directed_px.push_back(make_pixel(16'h0000, 255, 255, 0));
    directed_px.push_back(make_pixel(16'hFFFF, 255, 255, 255));
    directed_px.push_back(make_pixel(16'hFFFF, 128, 200, 1));
    directed_px.push_back(make_pixel(10922, 255, 255, 2));
    directed_px.push_back(make_pixel(10923, 255, 255, 3));
    directed_px.push_back(make_pixel(21845, 200, 180, 4));
    directed_px.push_back(make_pixel(21846, 200, 180, 5));
    directed_px.push_back(make_pixel(32767, 255, 255, 6));
    directed_px.push_back(make_pixel(32768, 255, 255, 7));
    directed_px.push_back(make_pixel(43690, 100, 255, 8));
    directed_px.push_back(make_pixel(43691, 100, 255, 9));
    directed_px.push_back(make_pixel(54613, 255, 77, 10));
    directed_px.push_back(make_pixel(54614, 255, 77, 11));
    directed_px.push_back(make_pixel(5461, 255, 255, 128));
    directed_px.push_back(make_pixel(60000, 1, 254, 127));
    directed_px.push_back(make_pixel(12345, 0, 173, 200));
    directed_px.push_back(make_pixel(40000, 0, 255, 255));
    directed_px.push_back(make_pixel(40000, 255, 0, 255));
    directed_px.push_back(make_pixel(16'hFFFF, 0, 0, 0));
    directed_px.push_back(make_pixel(16'h0000, 0, 0, 255));
    directed_px.push_back(make_pixel(16'h5555, 255, 1, 85));
    directed_px.push_back(make_pixel(16'hAAAA, 254, 255, 170));
    foreach (directed_px[i]) send_pixel(directed_px[i]);

    for (int n = 0; n < RANDOM_PIXELS; n++) begin
      steady <= (n >= STEADY_FIRST) && (n < STEADY_LAST);
      // Once, the input waits for the whole pipeline to empty before resuming.
      if (n == DRAIN_AT) drain_results();
      send_pixel(random_pixel());
    end
    steady <= 1'b0;

    drain_results();
    repeat (10) @(posedge clk);

    $display("Sent %0d pixels (%0d directed) and compared %0d results, with random",
             pixels_sent, directed_px.size(), checked_count);
    $display("idling on both sides, a stall-free stretch and one full drain mid-run.");
    if (fail_count == 0) begin
      $display("hsv_to_rgb_convert_tb: done, clean");
    end else begin
      $display("hsv_to_rgb_convert_tb: done, errors");
    end
    $finish;
  end

endmodule
